// ===== hdl/gtdl_pkg.sv =====
// Shared types and constants for the GNSS time and date latency correction unit.
`timescale 1ns / 1ps

package gtdl_pkg;

    // Elapsed time in milliseconds always fits below 2^27.
    localparam int ELAPSED_W = 27;
    localparam int PROD_W    = 37;

    localparam logic [ELAPSED_W-1:0] MS_PER_DAY = 27'd86400000;
    localparam logic [ELAPSED_W-1:0] MS_SAT     = 27'd86399999;

    typedef struct packed {
        logic [5:0] dd;
        logic [6:0] mo;
        logic [6:0] yy;
    } t_date_raw;

    typedef struct packed {
        logic [5:0]  hh;
        logic [6:0]  mm;
        logic [6:0]  ss;
        logic [6:0]  cc;
        logic [16:0] e_s;
        logic [9:0]  e_ms;
        logic        clamped;
        t_date_raw   date;
    } t_dec;

    typedef struct packed {
        logic [5:0] hour_sum;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] milli;
        logic       clamped;
        t_date_raw  date;
    } t_tod;

endpackage

// ===== hdl/gnss_time_date_latency_correct_unit.sv =====
// Top level of the GNSS time and date latency correction unit.
`timescale 1ns / 1ps

// A fix transaction is taken on every clock edge where start is high; busy is always low,
// so one fix can enter per cycle. Its corrected time and date appear on the result ports
// for one cycle with o_done high, once it has passed the input register, decode stages
// A to D, carry stages E to I and the result register. The constant-reciprocal multipliers
// in these stages split the decimal codes, break the elapsed time into seconds and
// milliseconds, and carry seconds and minutes.
// Results cannot be held off by the receiver and must be captured when o_done is high.
// The tick period register resets to 1 ms and should only be written while no fix is in
// flight.

module gnss_time_date_latency_correct_unit #(
    parameter int TICK_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [24:0]           i_time_code,
    input  logic [18:0]           i_date_code,
    input  logic [TICK_WIDTH-1:0] i_log_tick,
    input  logic [TICK_WIDTH-1:0] i_now_tick,
    input  logic                  i_cfg_we,
    input  logic [9:0]            i_cfg_wdata,
    output logic                  o_done,
    output logic [4:0]            o_hour_out,
    output logic [5:0]            o_minute_out,
    output logic [5:0]            o_second_out,
    output logic [9:0]            o_milli_out,
    output logic [4:0]            o_day_out,
    output logic [3:0]            o_month_out,
    output logic [6:0]            o_year_out,
    output logic                  o_day_rolled,
    output logic                  o_elapsed_clamped
);
    import gtdl_pkg::*;

    logic [9:0] r_tick_period;
    logic       dec_valid;
    t_dec       dec;
    logic       tod_valid;
    t_tod       tod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= 10'd1;
        end else if (i_cfg_we) begin
            r_tick_period <= i_cfg_wdata;
        end
    end

    assign busy = 1'b0;

    gtdl_decode #(
        .TICK_WIDTH(TICK_WIDTH)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start && !busy),
        .i_time_code   (i_time_code),
        .i_date_code   (i_date_code),
        .i_log_tick    (i_log_tick),
        .i_now_tick    (i_now_tick),
        .i_tick_period (r_tick_period),
        .o_valid       (dec_valid),
        .o_dec         (dec)
    );

    gtdl_carry u_carry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .i_dec   (dec),
        .o_valid (tod_valid),
        .o_tod   (tod)
    );

    gtdl_date u_date (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (tod_valid),
        .i_tod             (tod),
        .o_done            (o_done),
        .o_hour_out        (o_hour_out),
        .o_minute_out      (o_minute_out),
        .o_second_out      (o_second_out),
        .o_milli_out       (o_milli_out),
        .o_day_out         (o_day_out),
        .o_month_out       (o_month_out),
        .o_year_out        (o_year_out),
        .o_day_rolled      (o_day_rolled),
        .o_elapsed_clamped (o_elapsed_clamped)
    );

endmodule

// ===== hdl/gtdl_decode.sv =====
// Digit split of the time and date codes and elapsed-time computation.
`timescale 1ns / 1ps

module gtdl_decode #(
    parameter int TICK_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [24:0]           i_time_code,
    input  logic [18:0]           i_date_code,
    input  logic [TICK_WIDTH-1:0] i_log_tick,
    input  logic [TICK_WIDTH-1:0] i_now_tick,
    input  logic [9:0]            i_tick_period,
    output logic                  o_valid,
    output gtdl_pkg::t_dec        o_dec
);
    import gtdl_pkg::*;

    localparam logic [25:0] DIV10000_M = 26'd54975582;
    localparam logic [13:0] DIV100_M   = 14'd10486;
    localparam logic [27:0] DIV1000_M  = 28'd137438954;

    // Quotients by reciprocal multiplication, exact over the stated input ranges.
    function automatic logic [11:0] div10000(input logic [24:0] x);
        logic [50:0] p;
        p = 51'(x) * 51'(DIV10000_M);
        return p[50:39];
    endfunction

    function automatic logic [6:0] div100(input logic [13:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'(DIV100_M);
        return 7'(p >> 20);
    endfunction

    function automatic logic [16:0] div1000(input logic [ELAPSED_W-1:0] x);
        logic [54:0] p;
        p = 55'(x) * 55'(DIV1000_M);
        return p[53:37];
    endfunction

    // Input register
    logic                  r_in_valid;
    logic [24:0]           r_in_tc;
    logic [18:0]           r_in_dc;
    logic [TICK_WIDTH-1:0] r_in_log;
    logic [TICK_WIDTH-1:0] r_in_now;

    // Stage A
    logic                  r_a_valid;
    logic [PROD_W-1:0]     r_a_prod;
    logic                  r_a_hi;
    logic                  r_a_pzero;
    logic [11:0]           r_a_hhmm;
    logic [24:0]           r_a_tc;
    logic [5:0]            r_a_dd;
    logic [18:0]           r_a_dc;
    logic [TICK_WIDTH-1:0] n_diff;
    logic [ELAPSED_W-1:0]  n_diff_lo;
    logic [PROD_W-1:0]     n_prod;

    // Stage B
    logic                  r_b_valid;
    logic [11:0]           r_b_hhmm;
    logic [13:0]           r_b_sscc;
    logic [5:0]            r_b_dd;
    logic [13:0]           r_b_mmyy;
    logic [ELAPSED_W-1:0]  r_b_elapsed;
    logic                  r_b_clamped;
    logic                  n_clamped;
    logic [ELAPSED_W-1:0]  n_elapsed;

    // Stage C
    logic                  r_c_valid;
    logic [11:0]           r_c_hhmm;
    logic [13:0]           r_c_sscc;
    logic [13:0]           r_c_mmyy;
    logic [ELAPSED_W-1:0]  r_c_elapsed;
    logic [6:0]            r_c_hh;
    logic [6:0]            r_c_ss;
    logic [6:0]            r_c_mo;
    logic [16:0]           r_c_es;
    logic [5:0]            r_c_dd;
    logic                  r_c_clamped;

    // Stage D
    logic                  r_d_valid;
    t_dec                  r_d_dec;
    t_dec                  n_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_d_valid  <= 1'b0;
        end else begin
            r_in_valid <= i_start;
            r_a_valid  <= r_in_valid;
            r_b_valid  <= r_a_valid;
            r_c_valid  <= r_b_valid;
            r_d_valid  <= r_c_valid;
        end
    end

    always_comb begin
        n_diff    = r_in_now - r_in_log;
        n_diff_lo = ELAPSED_W'(n_diff);
        n_prod    = PROD_W'(n_diff_lo) * PROD_W'(i_tick_period);
    end

    always_comb begin
        // A zero tick period gives zero elapsed time even when the tick gap is huge.
        n_clamped = !r_a_pzero && (r_a_hi || (r_a_prod >= PROD_W'(MS_PER_DAY)));
        n_elapsed = n_clamped ? MS_SAT : r_a_prod[ELAPSED_W-1:0];
    end

    always_comb begin
        n_dec.hh        = 6'(r_c_hh);
        n_dec.mm        = 7'(r_c_hhmm - 12'(r_c_hh) * 12'd100);
        n_dec.ss        = r_c_ss;
        n_dec.cc        = 7'(r_c_sscc - 14'(r_c_ss) * 14'd100);
        n_dec.e_s       = r_c_es;
        n_dec.e_ms      = 10'(r_c_elapsed - ELAPSED_W'(r_c_es) * 27'd1000);
        n_dec.clamped   = r_c_clamped;
        n_dec.date.dd   = r_c_dd;
        n_dec.date.mo   = r_c_mo;
        n_dec.date.yy   = 7'(r_c_mmyy - 14'(r_c_mo) * 14'd100);
    end

    always_ff @(posedge i_clk) begin
        r_in_tc  <= i_time_code;
        r_in_dc  <= i_date_code;
        r_in_log <= i_log_tick;
        r_in_now <= i_now_tick;

        r_a_prod  <= n_prod;
        r_a_hi    <= (n_diff >> ELAPSED_W) != '0;
        r_a_pzero <= (i_tick_period == 10'd0);
        r_a_hhmm  <= div10000(r_in_tc);
        r_a_tc    <= r_in_tc;
        r_a_dd    <= 6'(div10000(25'(r_in_dc)));
        r_a_dc    <= r_in_dc;

        r_b_hhmm    <= r_a_hhmm;
        r_b_sscc    <= 14'(r_a_tc - 25'(r_a_hhmm) * 25'd10000);
        r_b_dd      <= r_a_dd;
        r_b_mmyy    <= 14'(r_a_dc - 19'(r_a_dd) * 19'd10000);
        r_b_elapsed <= n_elapsed;
        r_b_clamped <= n_clamped;

        r_c_hhmm    <= r_b_hhmm;
        r_c_sscc    <= r_b_sscc;
        r_c_mmyy    <= r_b_mmyy;
        r_c_elapsed <= r_b_elapsed;
        r_c_hh      <= div100(14'(r_b_hhmm));
        r_c_ss      <= div100(r_b_sscc);
        r_c_mo      <= div100(r_b_mmyy);
        r_c_es      <= div1000(r_b_elapsed);
        r_c_dd      <= r_b_dd;
        r_c_clamped <= r_b_clamped;

        r_d_dec <= n_dec;
    end

    assign o_valid = r_d_valid;
    assign o_dec   = r_d_dec;

endmodule

// ===== hdl/gtdl_carry.sv =====
// Carry chain from milliseconds through seconds and minutes into hours.
`timescale 1ns / 1ps

module gtdl_carry (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gtdl_pkg::t_dec i_dec,
    output logic           o_valid,
    output gtdl_pkg::t_tod o_tod
);
    import gtdl_pkg::*;

    localparam logic [17:0] DIV60_M = 18'd139811;

    // Exact for x below 122880.
    function automatic logic [10:0] div60(input logic [16:0] x);
        logic [34:0] p;
        p = 35'(x) * 35'(DIV60_M);
        return p[33:23];
    endfunction

    logic        r_e_valid, r_f_valid, r_g_valid, r_h_valid, r_i_valid;

    logic [16:0] r_e_sec_sum, r_f_sec_sum;
    logic [9:0]  r_e_milli, r_f_milli, r_g_milli, r_h_milli;
    logic [6:0]  r_e_mm, r_f_mm;
    logic [5:0]  r_e_hh, r_f_hh, r_g_hh, r_h_hh;
    logic        r_e_clamped, r_f_clamped, r_g_clamped, r_h_clamped;
    t_date_raw   r_e_date, r_f_date, r_g_date, r_h_date;
    logic [10:0] r_f_q;
    logic [5:0]  r_g_second, r_h_second;
    logic [10:0] r_g_min_sum, r_h_min_sum;
    logic [10:0] r_h_q;
    t_tod        r_i_tod;

    logic [10:0] n_ms;
    logic        n_ms_carry;
    logic [9:0]  n_milli;
    logic [16:0] n_sec_sum;
    t_tod        n_tod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
        end else begin
            r_e_valid <= i_valid;
            r_f_valid <= r_e_valid;
            r_g_valid <= r_f_valid;
            r_h_valid <= r_g_valid;
            r_i_valid <= r_h_valid;
        end
    end

    always_comb begin
        // Hundredths become milliseconds; the sum stays below 2000, so one carry at most.
        n_ms       = 11'(i_dec.cc) * 11'd10 + 11'(i_dec.e_ms);
        n_ms_carry = (n_ms >= 11'd1000);
        n_milli    = n_ms_carry ? 10'(n_ms - 11'd1000) : 10'(n_ms);
        n_sec_sum  = 17'(i_dec.ss) + i_dec.e_s + 17'(n_ms_carry);
    end

    always_comb begin
        n_tod.hour_sum = r_h_hh + 6'(r_h_q);
        n_tod.minute   = 6'(r_h_min_sum - r_h_q * 11'd60);
        n_tod.second   = r_h_second;
        n_tod.milli    = r_h_milli;
        n_tod.clamped  = r_h_clamped;
        n_tod.date     = r_h_date;
    end

    always_ff @(posedge i_clk) begin
        r_e_sec_sum <= n_sec_sum;
        r_e_milli   <= n_milli;
        r_e_mm      <= i_dec.mm;
        r_e_hh      <= i_dec.hh;
        r_e_clamped <= i_dec.clamped;
        r_e_date    <= i_dec.date;

        r_f_q       <= div60(r_e_sec_sum);
        r_f_sec_sum <= r_e_sec_sum;
        r_f_milli   <= r_e_milli;
        r_f_mm      <= r_e_mm;
        r_f_hh      <= r_e_hh;
        r_f_clamped <= r_e_clamped;
        r_f_date    <= r_e_date;

        r_g_second  <= 6'(r_f_sec_sum - 17'(r_f_q) * 17'd60);
        r_g_min_sum <= 11'(r_f_mm) + r_f_q;
        r_g_milli   <= r_f_milli;
        r_g_hh      <= r_f_hh;
        r_g_clamped <= r_f_clamped;
        r_g_date    <= r_f_date;

        r_h_q       <= div60(17'(r_g_min_sum));
        r_h_min_sum <= r_g_min_sum;
        r_h_second  <= r_g_second;
        r_h_milli   <= r_g_milli;
        r_h_hh      <= r_g_hh;
        r_h_clamped <= r_g_clamped;
        r_h_date    <= r_g_date;

        r_i_tod <= n_tod;
    end

    assign o_valid = r_i_valid;
    assign o_tod   = r_i_tod;

endmodule

// ===== hdl/gtdl_date.sv =====
// Hour wrap, date advance across midnight and the result register.
`timescale 1ns / 1ps

module gtdl_date (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gtdl_pkg::t_tod i_tod,
    output logic           o_done,
    output logic [4:0]     o_hour_out,
    output logic [5:0]     o_minute_out,
    output logic [5:0]     o_second_out,
    output logic [9:0]     o_milli_out,
    output logic [4:0]     o_day_out,
    output logic [3:0]     o_month_out,
    output logic [6:0]     o_year_out,
    output logic           o_day_rolled,
    output logic           o_elapsed_clamped
);
    import gtdl_pkg::*;

    localparam logic [6:0] MONTH_FEB = 7'd2;
    localparam logic [6:0] MONTH_DEC = 7'd12;
    localparam logic [6:0] YEAR_MAX  = 7'd99;

    logic       r_done;
    logic [4:0] r_hour;
    logic [5:0] r_minute;
    logic [5:0] r_second;
    logic [9:0] r_milli;
    logic [4:0] r_day;
    logic [3:0] r_month;
    logic [6:0] r_year;
    logic       r_rolled;
    logic       r_clamped;

    logic       n_rolled;
    logic [4:0] n_hour;
    logic [4:0] n_mlen;
    logic [5:0] n_day;
    logic [6:0] n_month;
    logic [6:0] n_year;

    always_comb begin
        // The hour sum never reaches 72, so at most two wraps are needed.
        n_rolled = (i_tod.hour_sum >= 6'd24);
        if (i_tod.hour_sum >= 6'd48) begin
            n_hour = 5'(i_tod.hour_sum - 6'd48);
        end else if (n_rolled) begin
            n_hour = 5'(i_tod.hour_sum - 6'd24);
        end else begin
            n_hour = 5'(i_tod.hour_sum);
        end
    end

    always_comb begin
        // Months outside one to twelve count as 31 days long.
        if (i_tod.date.mo inside {7'd4, 7'd6, 7'd9, 7'd11}) begin
            n_mlen = 5'd30;
        end else if (i_tod.date.mo == MONTH_FEB) begin
            n_mlen = (i_tod.date.yy[1:0] == 2'd0) ? 5'd29 : 5'd28;
        end else begin
            n_mlen = 5'd31;
        end
    end

    always_comb begin
        n_day   = i_tod.date.dd;
        n_month = i_tod.date.mo;
        n_year  = i_tod.date.yy;
        if (n_rolled) begin
            n_day = i_tod.date.dd + 6'd1;
            if (n_day > 6'(n_mlen)) begin
                n_day   = 6'd1;
                n_month = i_tod.date.mo + 7'd1;
            end
            if (n_month > MONTH_DEC) begin
                n_month = 7'd1;
                n_year  = i_tod.date.yy + 7'd1;
                if (n_year > YEAR_MAX) begin
                    n_year = 7'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hour    <= n_hour;
        r_minute  <= i_tod.minute;
        r_second  <= i_tod.second;
        r_milli   <= i_tod.milli;
        r_day     <= 5'(n_day);
        r_month   <= 4'(n_month);
        r_year    <= n_year;
        r_rolled  <= n_rolled;
        r_clamped <= i_tod.clamped;
    end

    assign o_done            = r_done;
    assign o_hour_out        = r_hour;
    assign o_minute_out      = r_minute;
    assign o_second_out      = r_second;
    assign o_milli_out       = r_milli;
    assign o_day_out         = r_day;
    assign o_month_out       = r_month;
    assign o_year_out        = r_year;
    assign o_day_rolled      = r_rolled;
    assign o_elapsed_clamped = r_clamped;

endmodule

// ===== hdl/gtdl_checker.sv =====
// Port-level assertions for the GNSS time and date latency correction unit, with its bind.
`timescale 1ns / 1ps

module gtdl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [4:0] o_hour_out,
    input logic [5:0] o_minute_out,
    input logic [5:0] o_second_out,
    input logic [9:0] o_milli_out,
    input logic [4:0] o_day_out,
    input logic [3:0] o_month_out,
    input logic [6:0] o_year_out,
    input logic       o_day_rolled
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy was raised");

    // Every accepted transaction produces exactly one result after the fixed latency.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##11 o_done)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 11))
        else $error("result without an accepted transaction");

    a_time_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hour_out < 5'd24 && o_minute_out < 6'd60 &&
                    o_second_out < 6'd60 && o_milli_out < 10'd1000))
        else $error("corrected time of day out of range");

    // After a midnight carry the day is always repaired into one to 31.
    a_rolled_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_day_rolled) |-> (o_day_out != 5'd0 && o_month_out <= 4'd12 &&
                                      o_year_out <= 7'd99))
        else $error("date not repaired after day rollover");

endmodule

bind gnss_time_date_latency_correct_unit gtdl_checker u_checker (.*);
